// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/mcaf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcaf_pkg
// Shared widths, defaults and the control word of the forecaster datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mcaf_pkg;

  // default configuration
  localparam int CHANNELS_DEF   = 2;
  localparam int AR_TAPS_DEF    = 2;
  localparam int MA_TAPS_DEF    = 2;
  localparam int DIFF_ORDER_DEF = 1;

  // stream widths
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 1;

  // datapath widths
  localparam int MEAS_W = 16;
  localparam int COEF_W = 16;
  localparam int OP_W   = 18;   // second difference of 16-bit values
  localparam int PROD_W = OP_W + COEF_W;
  localparam int ACC_W  = 42;   // covers 128 full-scale products plus raw term
  localparam int FRAC_W = 13;
  localparam int FC_W   = 20;
  localparam int RND_W  = ACC_W - FRAC_W;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [FC_W-1:0]  FC_MAX     = {1'b0, {(FC_W-1){1'b1}}};
  localparam logic signed [FC_W-1:0]  FC_MIN     = {1'b1, {(FC_W-1){1'b0}}};

  // one issued tap of the multiply-accumulate
  typedef struct packed {
    logic valid;
    logic start;      // first tap of a forecast: restart the sum
    logic final_tap;  // last tap of a forecast
    logic ar;         // measurement tap (else residual tap)
    logic use_tap;    // tap contributes (early taps only fill the difference history)
    logic raw;        // newest measurement of the forecast channel
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcaf_ram.sv =====
// ----------------------------------------------------------------------------
// mcaf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcaf_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcaf_mac.sv =====
// ----------------------------------------------------------------------------
// mcaf_mac
// Difference, multiply, accumulate, round and saturate for one forecast.
// ----------------------------------------------------------------------------
`default_nettype none

module mcaf_mac #(
  parameter int DIFF_ORDER = mcaf_pkg::DIFF_ORDER_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mcaf_pkg::mac_ctl_t                  issue,
  input  logic signed [mcaf_pkg::MEAS_W-1:0]  win_data,
  input  logic signed [mcaf_pkg::COEF_W-1:0]  coef_data,
  output logic                                done,
  output logic signed [mcaf_pkg::FC_W-1:0]    forecast,
  output logic                                saturated
);
  import mcaf_pkg::*;

  mac_ctl_t c1, c2, c3;
  logic     fin;

  logic signed [MEAS_W-1:0] h1, h2, raw;
  logic signed [OP_W-1:0]   x_ext, d1, d2, op_next, op;
  logic signed [COEF_W-1:0] cf;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, raw_term, sum;
  logic signed [RND_W-1:0]  rnd;
  logic                     ovf;

  assign x_ext = OP_W'(win_data);
  assign d1    = x_ext - OP_W'(h1);
  assign d2    = d1 - OP_W'(h1) + OP_W'(h2);

  always_comb begin
    if (!c1.use_tap) begin
      op_next = '0;
    end else if (!c1.ar || DIFF_ORDER == 0) begin
      op_next = x_ext;
    end else if (DIFF_ORDER == 1) begin
      op_next = d1;
    end else begin
      op_next = d2;
    end
  end

  assign raw_term = (DIFF_ORDER > 0) ? (ACC_W'(raw) <<< FRAC_W) : '0;
  assign sum      = acc + raw_term + ROUND_HALF;
  assign rnd      = sum[ACC_W-1:FRAC_W];
  assign ovf      = !((&rnd[RND_W-1:FC_W-1]) || !(|rnd[RND_W-1:FC_W-1]));

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      c1   <= '0;
      c2   <= '0;
      c3   <= '0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      c1  <= issue;
      c2  <= c1;
      c3  <= c2;
      fin <= c3.valid && c3.final_tap;
      if (fin) begin
        done <= 1'b1;
      end
      if (issue.valid && issue.start) begin
        done <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (c1.valid && c1.ar) begin
      h1 <= win_data;
      h2 <= h1;
    end
    if (c1.valid && c1.raw) begin
      raw <= win_data;
    end
    op   <= op_next;
    cf   <= coef_data;
    prod <= op * cf;
    if (c3.valid) begin
      acc <= (c3.start ? '0 : acc) + ACC_W'(prod);
    end
    if (fin) begin
      saturated <= ovf;
      if (ovf) begin
        forecast <= rnd[RND_W-1] ? FC_MIN : FC_MAX;
      end else begin
        forecast <= rnd[FC_W-1:0];
      end
    end
  end

  `include "assert_macros.svh"

  `ASSERT_PROP(a_done_clear, clk, rst, issue.valid && issue.start |=> !done)
  `ASSERT_PROP(a_done_rise, clk, rst, $rose(done) |-> $past(fin))
  `ASSERT_PROP(a_ma_used, clk, rst, c1.valid && !c1.ar |-> c1.use_tap)

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_arima_forecaster_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_arima_forecaster_core
// One-step vector ARIMA forecaster over CHANNELS channels.
// ----------------------------------------------------------------------------
// Coefficient items write one AR or MA coefficient. A sample item writes the
// channel's measurement into a circular window in the window RAM and, with MA
// taps, its residual into a second window in S_RES. A sample for the last
// channel starts the forecasts: each one streams CHANNELS*(AR_TAPS+DIFF_ORDER+
// MA_TAPS) taps through the single multiply-accumulate, one tap per cycle as
// set by the one read port of each RAM, then waits in S_WAIT until the output
// register is free. Inputs are refused while forecasts are computed; the last
// forecast may wait in the output register while new items are taken. After
// reset a clearing pass zeroes both RAMs over the larger of their depths,
// during which no item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_arima_forecaster_core #(
  parameter int CHANNELS   = mcaf_pkg::CHANNELS_DEF,
  parameter int AR_TAPS    = mcaf_pkg::AR_TAPS_DEF,
  parameter int MA_TAPS    = mcaf_pkg::MA_TAPS_DEF,
  parameter int DIFF_ORDER = mcaf_pkg::DIFF_ORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // channel[2:0], measure[18:3], residual[34:19], coef_index[43:35],
  // coef_value[59:44], zero fill
  input  logic [mcaf_pkg::S_TDATA_W-1:0]   s_tdata,
  // command[0], coef_kind[1]
  input  logic [mcaf_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_channel[2:0], forecast[22:3], zero fill
  output logic [mcaf_pkg::M_TDATA_W-1:0]   m_tdata,
  // saturated[0]
  output logic [mcaf_pkg::M_TUSER_W-1:0]   m_tuser,
  output logic                             m_tlast
);
  import mcaf_pkg::*;

  localparam int MWIN       = AR_TAPS + DIFF_ORDER;
  localparam int AR_SIZE    = CHANNELS * CHANNELS * AR_TAPS;
  localparam int MA_SIZE    = CHANNELS * CHANNELS * MA_TAPS;
  localparam int COEF_DEPTH = AR_SIZE + MA_SIZE;
  localparam int RES_BASE   = CHANNELS * MWIN;
  localparam int WIN_DEPTH  = CHANNELS * (MWIN + MA_TAPS);
  localparam int CLR_DEPTH  = (WIN_DEPTH > COEF_DEPTH) ? WIN_DEPTH : COEF_DEPTH;
  localparam int KMAX       = (MWIN > MA_TAPS) ? MWIN : MA_TAPS;
  localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WAW        = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int CLW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int MPW        = (MWIN > 1) ? $clog2(MWIN) : 1;
  localparam int RPW        = (MA_TAPS > 1) ? $clog2(MA_TAPS) : 1;
  localparam int KW         = (KMAX > 1) ? $clog2(KMAX) : 1;
  localparam int SW         = KW + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RES   = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  localparam logic CMD_COEF = 1'b1;
  localparam logic KIND_MA  = 1'b1;

  // input fields
  logic              in_cmd, in_kind;
  logic [2:0]        in_ch;
  logic [MEAS_W-1:0] in_meas, in_res;
  logic [8:0]        in_idx;
  logic [COEF_W-1:0] in_coef;

  assign in_cmd  = s_tuser[0];
  assign in_kind = s_tuser[1];
  assign in_ch   = s_tdata[2:0];
  assign in_meas = s_tdata[18:3];
  assign in_res  = s_tdata[34:19];
  assign in_idx  = s_tdata[43:35];
  assign in_coef = s_tdata[59:44];

  logic [2:0]        state;
  logic [CLW-1:0]    clr;
  logic [CW-1:0]     oi, si, lch;
  logic [KW-1:0]     k;
  logic              phase_ma;
  logic [CAW-1:0]    ar_ptr, ma_ptr;
  logic [MEAS_W-1:0] lres;
  logic [MPW-1:0]    mptr [CHANNELS];
  logic [RPW-1:0]    rptr [CHANNELS];

  logic              accept, ch_ok, ch_last, lch_last, sample_ok, coef_ok, start_fc;
  logic              out_free, out_load, use_tap, win_end, to_ma, src_end, fc_end;
  logic [CW-1:0]     pidx;
  logic [MPW-1:0]    mptr_cur, mptr_inc;
  logic [RPW-1:0]    rptr_cur, rptr_inc;
  logic [KW-1:0]     koff;
  logic [SW-1:0]     msum, mwr, rsum, rwr;
  logic [WAW-1:0]    m_addr, r_addr;

  logic              win_we, coef_we;
  logic [WAW-1:0]    win_waddr, win_raddr;
  logic [MEAS_W-1:0] win_wdata, win_rdata;
  logic [CAW-1:0]    coef_waddr, coef_raddr;
  logic [COEF_W-1:0] coef_wdata, coef_rdata;

  mac_ctl_t                 issue;
  logic                     mac_done, mac_sat;
  logic signed [FC_W-1:0]   mac_fc;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign ch_ok     = {1'b0, in_ch} < 4'(CHANNELS);
  assign ch_last   = (in_ch == 3'(CHANNELS - 1));
  assign lch_last  = (lch == CW'(CHANNELS - 1));
  assign sample_ok = accept && (in_cmd != CMD_COEF) && ch_ok;
  assign coef_ok   = (in_kind == KIND_MA) ? ({1'b0, in_idx} < 10'(MA_SIZE))
                                          : ({1'b0, in_idx} < 10'(AR_SIZE));
  assign start_fc  = (sample_ok && ch_last && MA_TAPS == 0) ||
                     (state == S_RES && lch_last);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == S_WAIT) && mac_done && out_free;

  // pointer row is read at one place: sample channel or current source
  always_comb begin
    case (state)
      S_MAC:   pidx = si;
      S_RES:   pidx = lch;
      default: pidx = in_ch[CW-1:0];
    endcase
  end

  assign mptr_cur = mptr[pidx];
  assign rptr_cur = rptr[pidx];
  assign mptr_inc = (mptr_cur == MPW'(MWIN - 1)) ? '0 : mptr_cur + 1'b1;
  assign rptr_inc = (rptr_cur == RPW'(MA_TAPS - 1)) ? '0 : rptr_cur + 1'b1;

  // oldest entry sits at the pointer; walk forward with wrap
  assign koff = (state == S_MAC) ? k : '0;
  assign msum = SW'(mptr_cur) + SW'(koff);
  assign mwr  = (msum >= SW'(MWIN)) ? msum - SW'(MWIN) : msum;
  assign rsum = SW'(rptr_cur) + SW'(koff);
  assign rwr  = (rsum >= SW'(MA_TAPS)) ? rsum - SW'(MA_TAPS) : rsum;

  assign m_addr = WAW'(pidx) * WAW'(MWIN) + WAW'(mwr);
  assign r_addr = WAW'(RES_BASE) + WAW'(pidx) * WAW'(MA_TAPS) + WAW'(rwr);

  // tap sequencing
  assign use_tap = phase_ma || (k >= KW'(DIFF_ORDER));
  assign win_end = phase_ma ? (k == KW'(MA_TAPS - 1)) : (k == KW'(MWIN - 1));
  assign to_ma   = !phase_ma && win_end && (MA_TAPS > 0);
  assign src_end = win_end && (phase_ma || MA_TAPS == 0);
  assign fc_end  = src_end && (si == CW'(CHANNELS - 1));

  always_comb begin
    issue           = '0;
    issue.valid     = (state == S_MAC);
    issue.start     = (si == '0) && !phase_ma && (k == '0);
    issue.final_tap = fc_end;
    issue.ar        = !phase_ma;
    issue.use_tap   = use_tap;
    issue.raw       = !phase_ma && (si == oi) && (k == KW'(MWIN - 1));
  end

  // RAM ports
  always_comb begin
    win_we     = 1'b0;
    win_waddr  = m_addr;
    win_wdata  = in_meas;
    coef_we    = 1'b0;
    coef_waddr = (in_kind == KIND_MA) ? CAW'(AR_SIZE) + CAW'(in_idx) : CAW'(in_idx);
    coef_wdata = in_coef;
    case (state)
      S_CLEAR: begin
        win_we     = {1'b0, clr} < (CLW + 1)'(WIN_DEPTH);
        win_waddr  = WAW'(clr);
        win_wdata  = '0;
        coef_we    = {1'b0, clr} < (CLW + 1)'(COEF_DEPTH);
        coef_waddr = CAW'(clr);
        coef_wdata = '0;
      end
      S_IDLE: begin
        win_we  = sample_ok;
        coef_we = accept && (in_cmd == CMD_COEF) && coef_ok;
      end
      S_RES: begin
        win_we    = 1'b1;
        win_waddr = r_addr;
        win_wdata = lres;
      end
      default: begin
        win_we  = 1'b0;
        coef_we = 1'b0;
      end
    endcase
  end

  assign win_raddr  = phase_ma ? r_addr : m_addr;
  assign coef_raddr = phase_ma ? ma_ptr : ar_ptr;

  mcaf_ram #(
    .WIDTH  (MEAS_W),
    .DEPTH  (WIN_DEPTH),
    .ADDR_W (WAW)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  mcaf_ram #(
    .WIDTH  (COEF_W),
    .DEPTH  (COEF_DEPTH),
    .ADDR_W (CAW)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  mcaf_mac #(
    .DIFF_ORDER (DIFF_ORDER)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .win_data  (win_rdata),
    .coef_data (coef_rdata),
    .done      (mac_done),
    .forecast  (mac_fc),
    .saturated (mac_sat)
  );

  // sequencer; window writes and forecast reads never overlap, the state
  // machine keeps them apart
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      oi       <= '0;
      si       <= '0;
      k        <= '0;
      phase_ma <= 1'b0;
      ar_ptr   <= '0;
      ma_ptr   <= '0;
      m_tvalid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        mptr[c] <= '0;
        rptr[c] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CLW'(CLR_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (sample_ok) begin
            mptr[pidx] <= mptr_inc;
            lch        <= in_ch[CW-1:0];
            lres       <= in_res;
            if (MA_TAPS > 0) begin
              state <= S_RES;
            end
          end
        end
        S_RES: begin
          rptr[pidx] <= rptr_inc;
          if (!start_fc) begin
            state <= S_IDLE;
          end
        end
        S_MAC: begin
          if (!phase_ma && use_tap) begin
            ar_ptr <= ar_ptr + 1'b1;
          end
          if (phase_ma) begin
            ma_ptr <= ma_ptr + 1'b1;
          end
          if (to_ma) begin
            phase_ma <= 1'b1;
            k        <= '0;
          end else if (src_end) begin
            phase_ma <= 1'b0;
            k        <= '0;
            if (fc_end) begin
              si    <= '0;
              state <= S_WAIT;
            end else begin
              si <= si + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_WAIT: begin
          if (out_load) begin
            m_tdata  <= {1'b0, mac_fc, 3'(oi)};
            m_tuser  <= mac_sat;
            m_tlast  <= (oi == CW'(CHANNELS - 1));
            if (oi == CW'(CHANNELS - 1)) begin
              state <= S_IDLE;
            end else begin
              oi    <= oi + 1'b1;
              state <= S_MAC;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (start_fc) begin
        oi       <= '0;
        si       <= '0;
        k        <= '0;
        phase_ma <= 1'b0;
        ar_ptr   <= '0;
        ma_ptr   <= CAW'(AR_SIZE);
        state    <= S_MAC;
      end
    end
  end

  `include "assert_macros.svh"

  `ASSERT_PROP(a_last_chan, clk, rst, m_tvalid && m_tlast |-> m_tdata[2:0] == 3'(CHANNELS - 1))
  `ASSERT_PROP(a_coef_range, clk, rst, state == S_MAC |-> coef_raddr <= CAW'(COEF_DEPTH - 1))
  `ASSERT_PROP(a_fc_wait, clk, rst, issue.valid && issue.final_tap |=> state == S_WAIT)
  `ASSERT_NEVER(a_wr_in_mac, clk, rst, (win_we || coef_we) && state == S_MAC)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multichannel ARIMA forecaster core. Coefficient
// writes and channel samples stream in. A local fixed-point model tracks the
// windows and coefficient tables and predicts every forecast a closed time
// step produces. The output stream is compared field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import mcaf_pkg::*;

  localparam int CHANNELS   = CHANNELS_DEF;
  localparam int AR_TAPS    = AR_TAPS_DEF;
  localparam int MA_TAPS    = MA_TAPS_DEF;
  localparam int DIFF_ORDER = DIFF_ORDER_DEF;
  localparam int MWIN       = AR_TAPS + DIFF_ORDER;
  localparam int RDEPTH     = (MA_TAPS > 0) ? MA_TAPS : 1;
  localparam int AR_SIZE    = CHANNELS * CHANNELS * AR_TAPS;
  localparam int MA_SIZE    = CHANNELS * CHANNELS * MA_TAPS;
  localparam int MA_STORE   = (MA_SIZE > 0) ? MA_SIZE : 1;
  localparam longint FC_HI  = 524287;
  localparam longint FC_LO  = -524288;
  localparam int RANDOM_ITEMS = 220;
  localparam int PHASE_LEN    = 30;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic {CMD_SAMPLE = 1'b0, CMD_COEF = 1'b1} cmd_e;
  typedef enum logic {KIND_AR = 1'b0, KIND_MA = 1'b1} kind_e;

  // idling phases
  localparam int PH_NONE   = 0;
  localparam int PH_SENDER = 1;
  localparam int PH_RECV   = 2;
  localparam int PH_BOTH   = 3;

  typedef struct {
    cmd_e              cmd;
    logic [2:0]        chan;
    logic signed [15:0] meas;
    logic signed [15:0] resid;
    kind_e             kind;
    logic [8:0]        index;
    logic signed [15:0] value;
    bit                drain;   // hold until every forecast has come back
    int                phase;
  } item_t;

  typedef struct {
    logic [2:0]  chan;
    logic [19:0] value;
    logic        sat;
    logic        last;
  } forecast_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic m_tlast;

  multichannel_arima_forecaster_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  shortint meas_win  [CHANNELS][MWIN];
  shortint resid_win [CHANNELS][RDEPTH];
  shortint ar_coef   [AR_SIZE];
  shortint ma_coef   [MA_STORE];

  item_t     pending_q[$];
  forecast_t forecast_q[$];
  item_t     cur_item;
  int        cur_phase = PH_NONE;
  int        n_items = 0;
  int        n_accepted = 0;
  int        n_samples = 0;
  int        n_coef = 0;
  int        n_ignored = 0;
  int        n_forecasts = 0;
  int        n_saturated = 0;
  int        n_errors = 0;
  int        n_cycles = 0;

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", n_cycles, what, want, got);
    n_errors++;
  endtask

  // Advance the model by one accepted item and queue the forecasts it causes.
  task automatic predict_step(input item_t it);
    longint    dif [CHANNELS][MWIN];
    longint    acc;
    longint    rounded;
    forecast_t fc;
    if (it.cmd == CMD_COEF) begin
      n_coef++;
      if (it.kind == KIND_AR && it.index < AR_SIZE) ar_coef[it.index] = it.value;
      else if (it.kind == KIND_MA && it.index < MA_SIZE) ma_coef[it.index] = it.value;
    end else if (it.chan >= CHANNELS) begin
      n_ignored++;
    end else begin
      n_samples++;
      for (int k = 0; k + 1 < MWIN; k++) meas_win[it.chan][k] = meas_win[it.chan][k+1];
      meas_win[it.chan][MWIN-1] = it.meas;
      if (MA_TAPS > 0) begin
        for (int k = 0; k + 1 < MA_TAPS; k++)
          resid_win[it.chan][k] = resid_win[it.chan][k+1];
        resid_win[it.chan][MA_TAPS-1] = it.resid;
      end
      if (it.chan == CHANNELS - 1) begin
        for (int s = 0; s < CHANNELS; s++) begin
          for (int k = 0; k < MWIN; k++) dif[s][k] = meas_win[s][k];
          for (int p = 0; p < DIFF_ORDER; p++)
            for (int k = MWIN - 1; k > 0; k--) dif[s][k] -= dif[s][k-1];
        end
        for (int oc = 0; oc < CHANNELS; oc++) begin
          acc = (DIFF_ORDER > 0) ? longint'(meas_win[oc][MWIN-1]) * 8192 : 0;
          for (int s = 0; s < CHANNELS; s++) begin
            for (int k = 0; k < AR_TAPS; k++)
              acc += longint'(ar_coef[(oc*CHANNELS + s)*AR_TAPS + k]) * dif[s][DIFF_ORDER+k];
            for (int k = 0; k < MA_TAPS; k++)
              acc += longint'(ma_coef[(oc*CHANNELS + s)*MA_TAPS + k])
                     * longint'(resid_win[s][k]);
          end
          // round half up, then floor to whole units
          rounded = (acc + 4096) >>> FRAC_W;
          fc.sat = 1'b0;
          if (rounded > FC_HI) begin
            rounded = FC_HI;
            fc.sat = 1'b1;
          end else if (rounded < FC_LO) begin
            rounded = FC_LO;
            fc.sat = 1'b1;
          end
          fc.chan  = oc[2:0];
          fc.value = rounded[19:0];
          fc.last  = (oc == CHANNELS - 1);
          forecast_q.push_back(fc);
        end
      end
    end
  endtask

  function automatic int sender_idle_pct(input int ph);
    return (ph == PH_SENDER) ? 48 : (ph == PH_BOTH) ? 22 : 0;
  endfunction

  function automatic int recv_stall_pct(input int ph);
    return (ph == PH_RECV) ? 48 : (ph == PH_BOTH) ? 22 : 0;
  endfunction

  // Mostly moderate values, full range now and then.
  function automatic logic signed [15:0] rand_word(input int span);
    if ($urandom_range(99) < 30) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic push_sample(input int ch, input logic signed [15:0] m,
                             input logic signed [15:0] r, input int ph);
    item_t it;
    it.cmd   = CMD_SAMPLE;
    it.chan  = ch[2:0];
    it.meas  = m;
    it.resid = r;
    it.kind  = kind_e'($urandom_range(1));
    it.index = 9'($urandom);
    it.value = 16'($urandom);
    it.drain = 1'b0;
    it.phase = ph;
    pending_q.push_back(it);
  endtask

  task automatic push_coef(input kind_e kd, input int idx, input logic signed [15:0] v,
                           input bit hold, input int ph);
    item_t it;
    it.cmd   = CMD_COEF;
    it.chan  = 3'($urandom);
    it.meas  = 16'($urandom);
    it.resid = 16'($urandom);
    it.kind  = kd;
    it.index = idx[8:0];
    it.value = v;
    it.drain = hold;
    it.phase = ph;
    pending_q.push_back(it);
  endtask

  // Driver: present the next pending item, hold it until transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_step(cur_item);
        n_accepted++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_q.size() > 0 && !(pending_q[0].drain && forecast_q.size() != 0)
            && $urandom_range(99) >= sender_idle_pct(pending_q[0].phase)) begin
          cur_item  = pending_q.pop_front();
          cur_phase = cur_item.phase;
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, cur_item.value, cur_item.index, cur_item.resid,
                       cur_item.meas, cur_item.chan};
          s_tuser  <= {cur_item.kind, cur_item.cmd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each forecast transfer against the oldest prediction.
  always @(posedge clk) begin
    forecast_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (forecast_q.size() == 0) begin
          report_mismatch("unexpected forecast on channel", -1, m_tdata[2:0]);
        end else begin
          want = forecast_q.pop_front();
          n_forecasts++;
          if (want.sat) n_saturated++;
          if (m_tdata[2:0] != want.chan)
            report_mismatch("out_channel", want.chan, m_tdata[2:0]);
          if (m_tdata[22:3] != want.value)
            report_mismatch("forecast", $signed(want.value), $signed(m_tdata[22:3]));
          if (m_tuser[0] != want.sat)
            report_mismatch("saturated", want.sat, m_tuser[0]);
          if (m_tlast != want.last)
            report_mismatch("last", want.last, m_tlast);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d forecasts outstanding",
               n_cycles, forecast_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int counted;
    int ph;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < MWIN; k++) meas_win[c][k] = 0;
      for (int k = 0; k < RDEPTH; k++) resid_win[c][k] = 0;
    end
    foreach (ar_coef[i]) ar_coef[i] = 0;
    foreach (ma_coef[i]) ma_coef[i] = 0;

    // directed: zero tables, extremes, ignored items, saturation both ways
    push_sample(CHANNELS - 1, 16'sh7FFF, 16'sh8000, PH_NONE);
    push_coef(KIND_MA, 0, 16'sh7FFF, 1'b0, PH_NONE);
    push_coef(KIND_MA, MA_SIZE - 1, 16'sh8000, 1'b0, PH_NONE);
    push_coef(KIND_AR, 0, 16'sh8000, 1'b0, PH_NONE);
    push_coef(KIND_AR, AR_SIZE, 16'sh1234, 1'b0, PH_NONE);
    push_coef(KIND_MA, 511, 16'sh7FFF, 1'b0, PH_NONE);
    push_sample(7, 16'sh7FFF, 16'sh7FFF, PH_NONE);
    push_sample(CHANNELS, 16'sh8000, 16'sh8000, PH_NONE);
    push_coef(KIND_AR, 1, 16'sh7FFF, 1'b0, PH_NONE);
    push_coef(KIND_AR, 3, 16'sh7FFF, 1'b0, PH_NONE);
    for (int rep = 0; rep < 2; rep++) begin
      for (int c = 0; c < CHANNELS; c++) push_sample(c, 16'sh8000, 16'sh8000, PH_NONE);
      for (int c = 0; c < CHANNELS; c++) push_sample(c, 16'sh7FFF, 16'sh7FFF, PH_NONE);
    end
    for (int c = 0; c < CHANNELS; c++) push_sample(c, 16'sh8000, 16'sh0001, PH_NONE);
    // skipped channel, then a repeated one
    push_sample(CHANNELS - 1, 16'sh0100, -16'sh0100, PH_NONE);
    push_sample(0, 16'sh0033, 16'sh0011, PH_NONE);
    push_sample(0, -16'sh0033, -16'sh0011, PH_NONE);
    push_sample(CHANNELS - 1, 16'sh0000, 16'sh0000, PH_NONE);
    // drain everything before leaving the large coefficients behind
    push_coef(KIND_AR, 1, 16'sh0000, 1'b1, PH_NONE);
    push_coef(KIND_AR, 3, 16'sh0000, 1'b0, PH_NONE);

    // random: mostly complete time steps, some writes, some noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      ph = (counted / PHASE_LEN) % 4;
      r = $urandom_range(99);
      if (r < 65) begin
        if ($urandom_range(99) < 30) begin
          push_coef(kind_e'($urandom_range(1)), $urandom_range(AR_SIZE - 1),
                    rand_word(3000), 1'b0, ph);
          counted++;
        end
        for (int c = 0; c < CHANNELS; c++) push_sample(c, rand_word(2000), rand_word(2000), ph);
        counted += CHANNELS;
      end else if (r < 78) begin
        push_coef(kind_e'($urandom_range(1)), $urandom_range(MA_SIZE - 1),
                  rand_word(3000), (counted > 120 && counted < 126), ph);
        counted++;
      end else if (r < 84) begin
        push_coef(kind_e'($urandom_range(1)), $urandom_range(511, AR_SIZE),
                  16'($urandom), 1'b0, ph);
      end else if (r < 90) begin
        push_sample($urandom_range(7, CHANNELS), 16'($urandom), 16'($urandom), ph);
      end else if (r < 95) begin
        push_sample(CHANNELS - 1, rand_word(2000), rand_word(2000), ph);
        counted++;
      end else begin
        push_sample(0, rand_word(2000), rand_word(2000), ph);
        for (int c = 0; c < CHANNELS; c++) push_sample(c, rand_word(2000), rand_word(2000), ph);
        counted += CHANNELS + 1;
      end
    end
    n_items = pending_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_items) @(posedge clk);
    while (forecast_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d samples, %0d coefficient writes, %0d ignored samples",
             n_items, n_samples, n_coef, n_ignored);
    $display("checked %0d forecasts, %0d of them clipped, over four idling mixes",
             n_forecasts, n_saturated);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
